[rtl/mtt_pkg.sv]
// mtt_pkg: shared constants, types and the note-value table for the
// multichannel tone timer. Used by every file of the block.
`default_nettype none

package mtt_pkg;

  // channel bank
  localparam int NUM_CHANNELS = 4;
  localparam int SCAN_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // field widths
  localparam int MODE_W   = 2;
  localparam int CH_W     = 2;
  localparam int FREQ_W   = 20;
  localparam int DUR_W    = 24;
  localparam int CODE_W   = 4;
  localparam int PERIOD_W = 16;
  localparam int MASK_W   = 4;
  localparam int TIME_W   = 32;
  localparam int IN_USE_W = 3;

  // command modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RAW   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VALUE = 2'd2;

  // register map
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_CLOCK    = 2'd0;
  localparam logic [1:0] REG_PRESCALE = 2'd1;
  localparam logic [1:0] REG_TEMPO    = 2'd2;
  localparam logic [1:0] REG_IN_USE   = 2'd3;

  localparam logic [7:0]  CLOCK_RESET = 8'd72;
  localparam logic [7:0]  TEMPO_RESET = 8'd120;

  // arithmetic constants
  localparam int CLOCK_SCALE = 1000000;
  localparam int BEAT_MS     = 60000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;

  // serial divider sizes
  localparam int DIV_N_W   = 28;
  localparam int DIV_D_W   = 20;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  typedef struct packed {
    logic [7:0]          clock_mhz;
    logic [15:0]         prescale;
    logic [7:0]          tempo_bpm;
    logic [IN_USE_W-1:0] in_use;
  } cfg_t;

  typedef struct packed {
    logic       known;
    logic [2:0] num;
    logic [3:0] den;
  } ratio_t;

  // note value as a fraction of one beat
  function automatic ratio_t note_ratio(input logic [CODE_W-1:0] code);
    ratio_t r;
    r = '{known: 1'b1, num: 3'd1, den: 4'd1};
    case (code)
      4'd0:    begin r.num = 3'd4; r.den = 4'd1; end
      4'd1:    begin r.num = 3'd2; r.den = 4'd1; end
      4'd2:    begin r.num = 3'd1; r.den = 4'd1; end
      4'd3:    begin r.num = 3'd1; r.den = 4'd2; end
      4'd4:    begin r.num = 3'd1; r.den = 4'd4; end
      4'd5:    begin r.num = 3'd1; r.den = 4'd8; end
      4'd6:    begin r.num = 3'd3; r.den = 4'd1; end
      4'd7:    begin r.num = 3'd3; r.den = 4'd2; end
      4'd8:    begin r.num = 3'd3; r.den = 4'd4; end
      4'd9:    begin r.num = 3'd2; r.den = 4'd3; end
      4'd10:   begin r.num = 3'd1; r.den = 4'd3; end
      default: r.known = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/mtt_ifs.sv]
// mtt_ifs: valid/ready channel interfaces for note/tick commands and for
// timer register updates. Depends on mtt_pkg.
`default_nettype none

interface mtt_cmd_if;
  import mtt_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CH_W-1:0]   channel;
  logic [FREQ_W-1:0] tone_freq;
  logic [DUR_W-1:0]  raw_len;
  logic [CODE_W-1:0] duration_code;

  modport source(output valid, mode, channel, tone_freq, raw_len, duration_code,
                 input ready);
  modport sink(input valid, mode, channel, tone_freq, raw_len, duration_code,
               output ready);
endinterface

interface mtt_res_if;
  import mtt_pkg::*;
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     out_channel;
  logic [PERIOD_W-1:0] period_value;
  logic                period_written;
  logic [PERIOD_W-1:0] compare_value;
  logic [MASK_W-1:0]   playing_mask;
  logic                last;

  modport source(output valid, out_channel, period_value, period_written, compare_value,
                 playing_mask, last, input ready);
  modport sink(input valid, out_channel, period_value, period_written, compare_value,
               playing_mask, last, output ready);
endinterface

`default_nettype wire

[rtl/mtt_divider.sv]
// mtt_divider: restoring divider, one quotient bit per cycle.
// Depends on mtt_pkg for operand widths.
`default_nettype none

module mtt_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mtt_pkg::DIV_N_W-1:0] dividend,
  input  logic [mtt_pkg::DIV_D_W-1:0] divisor,
  output logic                        done,
  output logic [mtt_pkg::DIV_N_W-1:0] quotient
);
  import mtt_pkg::*;

  logic [DIV_N_W-1:0]   quo;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem, quo[DIV_N_W-1]};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= dividend;
        rem <= '0;
        dsr <= divisor;
        cnt <= DIV_CNT_W'(DIV_N_W);
      end else if (cnt != '0) begin
        if (!diff[DIV_D_W]) begin
          rem <= diff[DIV_D_W-1:0];
          quo <= {quo[DIV_N_W-2:0], 1'b1};
        end else begin
          rem <= trial[DIV_D_W-1:0];
          quo <= {quo[DIV_N_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

[rtl/mtt_cfg_regs.sv]
// mtt_cfg_regs: APB register file for clock, prescaler, tempo and
// channels-in-use settings. Depends on mtt_pkg.
`default_nettype none

module mtt_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtt_pkg::PADDR_W-1:0] paddr,
  input  logic [mtt_pkg::PDATA_W-1:0] pwdata,
  output logic [mtt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output mtt_pkg::cfg_t               cfg
);
  import mtt_pkg::*;

  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_mhz <= CLOCK_RESET;
      cfg.prescale  <= '0;
      cfg.tempo_bpm <= TEMPO_RESET;
      cfg.in_use    <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CLOCK:    cfg.clock_mhz <= pwdata[7:0];
        REG_PRESCALE: cfg.prescale  <= pwdata[15:0];
        REG_TEMPO:    cfg.tempo_bpm <= pwdata[7:0];
        REG_IN_USE:   cfg.in_use    <= pwdata[IN_USE_W-1:0];
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_CLOCK:    prdata = PDATA_W'(cfg.clock_mhz);
      REG_PRESCALE: prdata = PDATA_W'(cfg.prescale);
      REG_TEMPO:    prdata = PDATA_W'(cfg.tempo_bpm);
      REG_IN_USE:   prdata = PDATA_W'(cfg.in_use);
    endcase
  end

endmodule

`default_nettype wire

[rtl/multichannel_tone_timer.sv]
// Multichannel tone timer: turns note commands into PWM period/compare updates
// and silences timed notes on millisecond ticks. An item is taken only when the
// block is idle. A tick scans one channel deadline per cycle, then sends one
// silence beat per expired channel. A note is set by the shared one-bit-per-cycle
// divider: a rest with a raw duration needs no division, a known note-value
// duration adds a duration division, and a tone adds a rate and then a frequency
// division. A stalled result beat holds the sequencer until the beat slot is free.
// Settings are written through the APB port at byte addresses 0, 4, 8 and 12.
`default_nettype none

module multichannel_tone_timer (
  input  logic                        clk,
  input  logic                        rst,
  mtt_cmd_if.sink                     cmd,
  mtt_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtt_pkg::PADDR_W-1:0] paddr,
  input  logic [mtt_pkg::PDATA_W-1:0] pwdata,
  output logic [mtt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import mtt_pkg::*;

  typedef enum logic [2:0] {
    IDLE, DUR_DIV, RATE_DIV, FREQ_DIV, FINISH, SCAN, EMIT
  } state_t;

  cfg_t                 cfg;
  state_t               state;
  logic [CH_W-1:0]      ch_q;
  logic [FREQ_W-1:0]    freq_q;
  logic [DUR_W-1:0]     dur_q;
  logic [PERIOD_W-1:0]  per_q;
  logic [TIME_W-1:0]    time_now;
  logic [NUM_CHANNELS-1:0] flags;
  logic [TIME_W-1:0]    deadline [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pending;
  logic [SCAN_W-1:0]    scan_idx;

  logic                 div_start;
  logic [DIV_N_W-1:0]   div_dividend;
  logic [DIV_D_W-1:0]   div_divisor;
  logic                 div_done;
  logic [DIV_N_W-1:0]   div_quo;

  logic                 accept;
  logic [IN_USE_W-1:0]  n_eff;
  logic                 ch_ok;
  ratio_t               ratio;
  logic [7:0]           bpm_eff;
  logic                 slot_free;
  logic                 load_beat;
  logic                 tone;
  logic                 arm;
  logic [NUM_CHANNELS-1:0] flags_note;
  logic [TIME_W-1:0]    dl_sum;
  logic [TIME_W-1:0]    elapsed;
  logic                 scan_hit;
  logic [DIV_N_W-1:0]   rate_dividend;
  logic [DIV_D_W-1:0]   rate_divisor;
  logic [DIV_N_W-1:0]   beat_dividend;
  logic [DIV_D_W-1:0]   beat_divisor;
  logic [PERIOD_W-1:0]  per_next;
  logic [SCAN_W-1:0]    pick_idx;
  logic [NUM_CHANNELS-1:0] pick_bit;
  logic [NUM_CHANNELS-1:0] pending_left;

  mtt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtt_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // command decode
  assign cmd.ready = (state == IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign n_eff     = (cfg.in_use > IN_USE_W'(NUM_CHANNELS)) ? IN_USE_W'(NUM_CHANNELS)
                                                            : cfg.in_use;
  assign ch_ok     = IN_USE_W'(cmd.channel) < n_eff;
  assign ratio     = note_ratio(cmd.duration_code);
  assign bpm_eff   = (cfg.tempo_bpm == '0) ? 8'd1 : cfg.tempo_bpm;
  assign slot_free = !res.valid || res.ready;

  // a new result beat is loaded from FINISH, or from EMIT while a silence is pending
  assign load_beat = slot_free && ((state == FINISH) || (state == EMIT && pending != '0));

  // divider operands
  assign rate_dividend = DIV_N_W'(cfg.clock_mhz) * DIV_N_W'(CLOCK_SCALE);
  assign rate_divisor  = DIV_D_W'({1'b0, cfg.prescale} + 17'd1);
  assign beat_dividend = DIV_N_W'(BEAT_MS) * DIV_N_W'(ratio.num);
  assign beat_divisor  = DIV_D_W'({4'd0, bpm_eff} * {8'd0, ratio.den});

  // period clamp from the final quotient
  assign per_next = (div_quo == '0 || div_quo > DIV_N_W'(32'd65536)) ? PERIOD_MAX
                                                                      : PERIOD_W'(div_quo - 1'b1);

  // note channel update
  always_comb begin
    tone       = (freq_q != '0);
    arm        = !tone || (dur_q != '0);
    flags_note = flags;
    flags_note[ch_q] = arm;
    dl_sum     = time_now + TIME_W'(dur_q);
  end

  // deadline check for the channel under scan
  assign elapsed  = time_now - deadline[scan_idx];
  assign scan_hit = (IN_USE_W'(scan_idx) < n_eff) && flags[scan_idx] && !elapsed[TIME_W-1];

  // lowest pending channel
  always_comb begin
    pick_idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick_idx = SCAN_W'(i);
      end
    end
    pick_bit     = NUM_CHANNELS'(1) << pick_idx;
    pending_left = pending & ~pick_bit;
  end

  // sequencer, channel state and output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      time_now  <= '0;
      flags     <= '0;
      res.valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (load_beat) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            ch_q   <= cmd.channel;
            freq_q <= cmd.tone_freq;
            dur_q  <= (cmd.mode == MODE_RAW) ? cmd.raw_len : '0;
            case (cmd.mode) inside
              MODE_TICK: begin
                time_now <= time_now + 1'b1;
                pending  <= '0;
                scan_idx <= '0;
                state    <= SCAN;
              end
              MODE_RAW, MODE_VALUE: begin
                if (ch_ok) begin
                  if (cmd.mode == MODE_VALUE && ratio.known) begin
                    div_start    <= 1'b1;
                    div_dividend <= beat_dividend;
                    div_divisor  <= beat_divisor;
                    state        <= DUR_DIV;
                  end else if (cmd.tone_freq != '0) begin
                    div_start    <= 1'b1;
                    div_dividend <= rate_dividend;
                    div_divisor  <= rate_divisor;
                    state        <= RATE_DIV;
                  end else begin
                    state <= FINISH;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        DUR_DIV: begin
          if (div_done) begin
            dur_q <= div_quo[DUR_W-1:0];
            if (tone) begin
              div_start    <= 1'b1;
              div_dividend <= rate_dividend;
              div_divisor  <= rate_divisor;
              state        <= RATE_DIV;
            end else begin
              state <= FINISH;
            end
          end
        end
        RATE_DIV: begin
          if (div_done) begin
            div_start    <= 1'b1;
            div_dividend <= div_quo;
            div_divisor  <= freq_q;
            state        <= FREQ_DIV;
          end
        end
        FREQ_DIV: begin
          if (div_done) begin
            per_q <= per_next;
            state <= FINISH;
          end
        end
        FINISH: begin
          if (slot_free) begin
            flags <= flags_note;
            if (arm) begin
              deadline[ch_q] <= dl_sum;
            end
            res.out_channel    <= ch_q;
            res.period_value   <= tone ? per_q : '0;
            res.period_written <= tone;
            res.compare_value  <= tone ? {1'b0, per_q[PERIOD_W-1:1]} : '0;
            res.playing_mask   <= MASK_W'(flags_note);
            res.last           <= 1'b1;
            state              <= IDLE;
          end
        end
        SCAN: begin
          pending[scan_idx] <= scan_hit;
          if (scan_idx == SCAN_W'(NUM_CHANNELS - 1)) begin
            state <= EMIT;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        EMIT: begin
          if (pending == '0) begin
            state <= IDLE;
          end else if (slot_free) begin
            flags              <= flags & ~pick_bit;
            pending            <= pending_left;
            res.out_channel    <= CH_W'(pick_idx);
            res.period_value   <= '0;
            res.period_written <= 1'b0;
            res.compare_value  <= '0;
            res.playing_mask   <= MASK_W'(flags & ~pick_bit);
            res.last           <= (pending_left == '0);
            if (pending_left == '0) begin
              state <= IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/mtt_checker.sv]
// mtt_checker: port-level assertions on the result channel of the tone timer,
// bound to multichannel_tone_timer. Depends on mtt_pkg.
`default_nettype none

module mtt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [mtt_pkg::CH_W-1:0]     res_out_channel,
  input logic [mtt_pkg::PERIOD_W-1:0] res_period_value,
  input logic                         res_period_written,
  input logic [mtt_pkg::PERIOD_W-1:0] res_compare_value,
  input logic                         res_last
);
  import mtt_pkg::*;

  // a stalled beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  // a stalled beat keeps its channel and last mark
  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_out_channel) && $stable(res_last))
    else $error("result beat changed while stalled");

  // a tone runs at half duty
  a_half_duty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_period_written |->
      res_compare_value == {1'b0, res_period_value[PERIOD_W-1:1]})
    else $error("compare is not half the period");

  // silence and rest beats leave the period alone and zero the compare
  a_silence: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_period_written |->
      res_period_value == '0 && res_compare_value == '0)
    else $error("silence beat carries a period or compare");

endmodule

bind multichannel_tone_timer mtt_checker u_mtt_checker (
  .clk                (clk),
  .rst                (rst),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_out_channel    (res.out_channel),
  .res_period_value   (res.period_value),
  .res_period_written (res.period_written),
  .res_compare_value  (res.compare_value),
  .res_last           (res.last)
);

`default_nettype wire

[dv/tb_multichannel_tone_timer.sv]
`timescale 1ns / 1ps
// tb_multichannel_tone_timer: self-checking testbench for the multichannel tone timer.
// Drives note/tick beats and APB settings, predicts every timer update and checks it.
// Depends on mtt_pkg, the mtt_ifs interfaces and the multichannel_tone_timer RTL.

module tb_multichannel_tone_timer;
  import mtt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int SETTLE_CYCLES    = 128;
  localparam int HOLD_CYCLES      = 300;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CH_W-1:0]   channel;
    logic [FREQ_W-1:0] tone_freq;
    logic [DUR_W-1:0]  raw_len;
    logic [CODE_W-1:0] duration_code;
  } tone_cmd_t;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [PERIOD_W-1:0] period;
    logic                written;
    logic [PERIOD_W-1:0] compare;
    logic [MASK_W-1:0]   mask;
    logic                last;
  } timer_update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  mtt_cmd_if cmd_if();
  mtt_res_if res_if();

  multichannel_tone_timer dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the settings and the channel state
  logic [7:0]          clock_mhz_q = CLOCK_RESET;
  logic [15:0]         prescale_q  = '0;
  logic [7:0]          tempo_q     = TEMPO_RESET;
  logic [IN_USE_W-1:0] in_use_q    = '0;
  logic [TIME_W-1:0]   now_ms      = '0;
  logic [NUM_CHANNELS-1:0] sounding = '0;
  logic [TIME_W-1:0]   deadline [NUM_CHANNELS];

  tone_cmd_t     cmd_backlog[$];
  tone_cmd_t     on_bus;
  timer_update_t updates_due[$];

  int beats_queued  = 0;
  int beats_taken   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  int hold_left     = 0;
  logic hold_start  = 1'b0;

  function automatic int active_channels();
    return (in_use_q > NUM_CHANNELS) ? NUM_CHANNELS : int'(in_use_q);
  endfunction

  // note value length at the current tempo, exact integer floor
  function automatic logic [TIME_W-1:0] beat_fraction_ms(input logic [CODE_W-1:0] code);
    longint unsigned num;
    longint unsigned den;
    longint unsigned bpm;
    bpm = (tempo_q == 8'd0) ? 64'd1 : 64'(tempo_q);
    num = 0;
    den = 1;
    case (code)
      4'd0:    begin num = 4; den = 1; end
      4'd1:    begin num = 2; den = 1; end
      4'd2:    begin num = 1; den = 1; end
      4'd3:    begin num = 1; den = 2; end
      4'd4:    begin num = 1; den = 4; end
      4'd5:    begin num = 1; den = 8; end
      4'd6:    begin num = 3; den = 1; end
      4'd7:    begin num = 3; den = 2; end
      4'd8:    begin num = 3; den = 4; end
      4'd9:    begin num = 2; den = 3; end
      4'd10:   begin num = 1; den = 3; end
      default: num = 0;
    endcase
    return TIME_W'((64'(BEAT_MS) * num) / (den * bpm));
  endfunction

  // auto-reload value, saturating on overflow and on a zero quotient
  function automatic logic [PERIOD_W-1:0] tone_period(input logic [FREQ_W-1:0] freq);
    longint unsigned rate;
    longint unsigned quot;
    rate = (64'(clock_mhz_q) * 64'(CLOCK_SCALE)) / (64'(prescale_q) + 64'd1);
    quot = rate / 64'(freq);
    if (quot == 0 || quot - 1 > 64'(PERIOD_MAX)) return PERIOD_MAX;
    return PERIOD_W'(quot - 1);
  endfunction

  // advance the shadow state by one accepted beat and queue its updates
  function automatic void apply_command(input tone_cmd_t c);
    timer_update_t u;
    logic [TIME_W-1:0] dur;
    logic [PERIOD_W-1:0] per;
    bit found;
    int active;
    active = active_channels();
    found = 1'b0;
    u = '0;
    if (c.mode == MODE_TICK) begin
      now_ms = now_ms + 1;
      for (int i = 0; i < active; i++) begin
        if (sounding[i] && (now_ms - deadline[i]) < 32'h8000_0000) begin
          sounding[i] = 1'b0;
          if (found) updates_due.push_back(u);
          u = '{ch: CH_W'(i), period: '0, written: 1'b0, compare: '0,
                mask: sounding, last: 1'b0};
          found = 1'b1;
        end
      end
      if (found) begin
        u.last = 1'b1;
        updates_due.push_back(u);
      end
      return;
    end
    if (c.mode == MODE_UNUSED || int'(c.channel) >= active) return;
    dur = (c.mode == MODE_RAW) ? TIME_W'(c.raw_len) : beat_fraction_ms(c.duration_code);
    if (c.tone_freq == '0) begin
      // rest arms a deadline even for a zero length
      sounding[c.channel] = 1'b1;
      deadline[c.channel] = now_ms + dur;
      u = '{ch: c.channel, period: '0, written: 1'b0, compare: '0,
            mask: sounding, last: 1'b1};
    end else begin
      per = tone_period(c.tone_freq);
      if (dur != '0) begin
        sounding[c.channel] = 1'b1;
        deadline[c.channel] = now_ms + dur;
      end else begin
        sounding[c.channel] = 1'b0;
      end
      u = '{ch: c.channel, period: per, written: 1'b1, compare: per >> 1,
            mask: sounding, last: 1'b1};
    end
    updates_due.push_back(u);
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid         <= 1'b0;
      cmd_if.mode          <= MODE_TICK;
      cmd_if.channel       <= '0;
      cmd_if.tone_freq     <= '0;
      cmd_if.raw_len       <= '0;
      cmd_if.duration_code <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        apply_command(on_bus);
        beats_taken++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = cmd_backlog.pop_front();
          cmd_if.valid         <= 1'b1;
          cmd_if.mode          <= on_bus.mode;
          cmd_if.channel       <= on_bus.channel;
          cmd_if.tone_freq     <= on_bus.tone_freq;
          cmd_if.raw_len       <= on_bus.raw_len;
          cmd_if.duration_code <= on_bus.duration_code;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // update monitor and checker
  always @(posedge clk) begin
    timer_update_t got;
    timer_update_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{ch: res_if.out_channel, period: res_if.period_value,
                written: res_if.period_written, compare: res_if.compare_value,
                mask: res_if.playing_mask, last: res_if.last};
        if (updates_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("[%0t] unexpected update: ch=%0d per=%0d pw=%0b cmp=%0d mask=%h last=%0b",
                     $time, got.ch, got.period, got.written, got.compare, got.mask, got.last);
        end else begin
          want = updates_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
              $display({"[%0t] update mismatch: exp ch=%0d per=%0d pw=%0b cmp=%0d mask=%h",
                        " last=%0b / got ch=%0d per=%0d pw=%0b cmp=%0d mask=%h last=%0b"},
                       $time, want.ch, want.period, want.written, want.compare, want.mask,
                       want.last, got.ch, got.period, got.written, got.compare, got.mask,
                       got.last);
          end
        end
      end
      res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // apb write: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [1:0] index, input logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({index, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      REG_CLOCK:    clock_mhz_q = value[7:0];
      REG_PRESCALE: prescale_q  = value[15:0];
      REG_TEMPO:    tempo_q     = value[7:0];
      REG_IN_USE:   in_use_q    = value[IN_USE_W-1:0];
      default:      ;
    endcase
  endtask

  task automatic set_config(input int mhz, input int prescale, input int bpm, input int in_use);
    apb_write(REG_CLOCK, PDATA_W'(mhz));
    apb_write(REG_PRESCALE, PDATA_W'(prescale));
    apb_write(REG_TEMPO, PDATA_W'(bpm));
    apb_write(REG_IN_USE, PDATA_W'(in_use));
  endtask

  function automatic tone_cmd_t make_cmd(input logic [MODE_W-1:0] m, input int ch,
                                         input int f, input int d, input int code);
    return '{mode: m, channel: CH_W'(ch), tone_freq: FREQ_W'(f),
             raw_len: DUR_W'(d), duration_code: CODE_W'(code)};
  endfunction

  function automatic void queue_cmd(input tone_cmd_t c);
    cmd_backlog.push_back(c);
    beats_queued++;
  endfunction

  // mostly ticks and notes with short lengths so deadlines expire often
  function automatic tone_cmd_t random_cmd();
    tone_cmd_t c;
    int pick;
    pick = $urandom_range(99);
    c.mode = (pick < 45) ? MODE_TICK : (pick < 70) ? MODE_RAW :
             (pick < 95) ? MODE_VALUE : MODE_UNUSED;
    c.channel = CH_W'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 15)      c.tone_freq = '0;
    else if (pick < 25) c.tone_freq = FREQ_W'($urandom);
    else if (pick < 35) c.tone_freq = FREQ_W'($urandom_range(20, 1));
    else                c.tone_freq = FREQ_W'($urandom_range(20000, 20));
    pick = $urandom_range(99);
    if (pick < 20)      c.raw_len = '0;
    else if (pick < 80) c.raw_len = DUR_W'($urandom_range(30, 1));
    else if (pick < 90) c.raw_len = DUR_W'($urandom_range(300, 31));
    else                c.raw_len = DUR_W'($urandom);
    c.duration_code = CODE_W'($urandom_range(15));
    return c;
  endfunction

  // wait until every beat is taken and every update seen, then let the block settle
  task automatic drain();
    while (beats_taken != beats_queued || updates_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int target, input int send_idle, input int stall,
                            input bit squeeze);
    send_idle_pct = send_idle;
    stall_pct = stall;
    repeat (target) queue_cmd(random_cmd());
    if (squeeze) begin
      @(posedge clk);
      hold_start <= 1'b1;
      @(posedge clk);
      hold_start <= 1'b0;
    end
    drain();
  endtask

  // stimulus sequence
  initial begin
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, rests, holds, every note value, ignored mode
    set_config(72, 0, 255, 4);
    queue_cmd(make_cmd(MODE_RAW, 0, 440, 3, 0));
    queue_cmd(make_cmd(MODE_RAW, 1, 1, 0, 0));
    queue_cmd(make_cmd(MODE_RAW, 2, 20'hFFFFF, 24'hFFFFFF, 15));
    queue_cmd(make_cmd(MODE_RAW, 3, 0, 0, 0));
    queue_cmd(make_cmd(MODE_TICK, 0, 0, 0, 0));
    queue_cmd(make_cmd(MODE_UNUSED, 0, 1000, 5, 2));
    for (int code = 0; code < 16; code++)
      queue_cmd(make_cmd(MODE_VALUE, code % 4, (code % 2 != 0) ? 0 : 200 + 100 * code,
                         0, code));
    repeat (3) queue_cmd(make_cmd(MODE_TICK, 3, 20'hFFFFF, 24'hFFFFFF, 15));
    drain();

    // random phases over extreme and typical settings
    set_config(255, 65535, 1, 7);
    run_random(50, 0, 0, 1'b0);
    set_config(1, 0, 200, 3);
    run_random(45, 48, 0, 1'b0);
    set_config(72, 1, 0, 4);
    run_random(45, 0, 48, 1'b0);
    set_config(0, 7, 180, 2);
    run_random(45, 36, 36, 1'b0);
    set_config(100, 2, 255, 0);
    run_random(10, 36, 36, 1'b0);
    // receiver holds off while beats keep coming
    set_config(100, 0, 240, 4);
    run_random(40, 0, 0, 1'b1);

    if (mismatches == 0 && updates_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
